>>> rtl/core/pffs_pkg.sv
// Shared types, constants and helper functions for the packet flow filter and stats unit.
// Used by pffs_flow_cell, pffs_flow_table and packet_flow_filter_stats_unit.
package pffs_pkg;

    localparam int FLOW_ENTRIES = 64;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    localparam logic [2:0] MODE_NONE = 3'd0;
    localparam logic [2:0] MODE_TCP  = 3'd1;
    localparam logic [2:0] MODE_UDP  = 3'd2;
    localparam logic [2:0] MODE_ADDR = 3'd3;
    localparam logic [2:0] MODE_PORT = 3'd4;

    localparam logic [1:0] REG_FILTER_MODE    = 2'd0;
    localparam logic [1:0] REG_FILTER_ADDRESS = 2'd1;
    localparam logic [1:0] REG_FILTER_PORT    = 2'd2;

    localparam int CNT_W  = 32;
    localparam int FLOW_W = 7;
    localparam logic [FLOW_W-1:0] FLOW_CNT_MAX = '1;

    localparam int IN_W  = 136;
    localparam int OUT_W = 216;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
    } flow_key_t;

    typedef struct packed {
        logic found;
        logic full;
    } lookup_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [15:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W-15){1'b0}}, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic logic [FLOW_W-1:0] sat_inc_flow(input logic [FLOW_W-1:0] c);
        return (c == FLOW_CNT_MAX) ? c : c + FLOW_W'(1);
    endfunction

endpackage

>>> rtl/core/pffs_flow_cell.sv
// One entry of the flow table: a stored five-tuple, its valid bit and a registered match.
// Depends on pffs_pkg for the key type.
module pffs_flow_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  pffs_pkg::flow_key_t key,
    input  logic               prev_valid,
    input  logic               insert,
    output logic               valid,
    output logic               match
);

    pffs_pkg::flow_key_t key_reg;
    logic                valid_reg;
    logic                match_reg;
    logic                first_free;

    // Entries fill from the bottom and are never freed, so this cell is the
    // lowest free one exactly when its lower neighbor is occupied and it is not.
    assign first_free = prev_valid && !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= valid_reg && (key_reg == key);
            if (insert && first_free)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert && first_free)
        begin
            key_reg <= key;
        end
    end

    assign valid = valid_reg;
    assign match = match_reg;

endmodule

>>> rtl/core/pffs_flow_table.sv
// Flow table built as a row of pffs_flow_cell instances chained through their valid bits.
// Depends on pffs_pkg and pffs_flow_cell.
module pffs_flow_table
(
    input  logic                clk,
    input  logic                rst_n,
    input  pffs_pkg::flow_key_t key,
    input  logic                insert,
    output pffs_pkg::lookup_t   status
);

    logic [pffs_pkg::FLOW_ENTRIES:0]   valid_chain;
    logic [pffs_pkg::FLOW_ENTRIES-1:0] match_vec;

    assign valid_chain[0] = 1'b1;

    genvar i;
    generate
        for (i = 0; i < pffs_pkg::FLOW_ENTRIES; i++)
        begin : g_cell
            pffs_flow_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .key        (key),
                .prev_valid (valid_chain[i]),
                .insert     (insert),
                .valid      (valid_chain[i+1]),
                .match      (match_vec[i])
            );
        end
    endgenerate

    assign status.found = |match_vec;
    assign status.full  = valid_chain[pffs_pkg::FLOW_ENTRIES];

endmodule

>>> rtl/core/packet_flow_filter_stats_unit.sv
// Top level of the packet flow filter and stats unit: stream ports, filter, counters, control.
// Depends on pffs_pkg and pffs_flow_table (which instantiates pffs_flow_cell).
//
//  Channel   Direction  Handshake         Payload
//  --------  ---------  ----------------  ---------------------------------------------
//  s_*       in         s_tvalid/tready   one parsed packet header, 136 bits
//  m_*       out        m_tvalid/tready   filter flags and all totals, 216 bits
//  cfg_*     in         cfg_valid/ready   register index and write data
//
// Each header goes through the transfer in, a compare step in which every flow cell
// compares the header's five-tuple with its stored key, and an update step in which the
// counters are updated, a new flow is written into the lowest free cell and the result
// is loaded into the output register. Reset clears all counters, the filter registers and
// every cell's valid bit; stored keys are not cleared. While the output register holds a
// result that has not been taken, the update cycle waits; a new header is taken as soon as
// the previous one has been handed to the output register, even if that result is still
// waiting downstream.
module packet_flow_filter_stats_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    // s_tdata, from bit 0: etype[15:0], ip_protocol[23:16], source_address[55:24],
    // dest_address[87:56], source_port[103:88], dest_port[119:104],
    // captured_length[135:120]
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [pffs_pkg::IN_W-1:0]  s_tdata,
    // m_tdata, from bit 0: passed[0], new_flow[1], table_full[2], packet_total[34:3],
    // tcp_packet_total[66:35], udp_packet_total[98:67], other_packet_total[130:99],
    // flow_total[137:131], tcp_flow_total[144:138], udp_flow_total[151:145],
    // tcp_byte_total[183:152], udp_byte_total[215:184]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pffs_pkg::OUT_W-1:0] m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [31:0]                cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] state_reg, state_next;

    // Configuration registers.
    logic [2:0]  mode_reg;
    logic [31:0] faddr_reg;
    logic [15:0] fport_reg;

    // Header captured at the input transfer.
    logic [15:0]         etype_reg;
    logic [15:0]         len_reg;
    pffs_pkg::flow_key_t key_reg;

    logic pass_reg, pass_next;

    // Running totals.
    logic [pffs_pkg::CNT_W-1:0]  pkt_total_reg, pkt_tcp_reg, pkt_udp_reg, pkt_other_reg;
    logic [pffs_pkg::CNT_W-1:0]  pkt_total_next, pkt_tcp_next, pkt_udp_next, pkt_other_next;
    logic [pffs_pkg::FLOW_W-1:0] flow_total_reg, flow_tcp_reg, flow_udp_reg;
    logic [pffs_pkg::FLOW_W-1:0] flow_total_next, flow_tcp_next, flow_udp_next;
    logic [pffs_pkg::CNT_W-1:0]  byte_tcp_reg, byte_udp_reg;
    logic [pffs_pkg::CNT_W-1:0]  byte_tcp_next, byte_udp_next;

    logic                       out_valid_reg;
    logic [pffs_pkg::OUT_W-1:0] out_data_reg;

    logic              in_fire;
    logic              upd_fire;
    logic              is_tcp, is_udp, is_ip;
    logic              do_lookup;
    logic              insert;
    logic              full_flag;
    pffs_pkg::lookup_t status;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign upd_fire  = (state_reg == ST_UPD) && (!out_valid_reg || m_tready);

    assign is_tcp = (key_reg.proto == pffs_pkg::PROTO_TCP);
    assign is_udp = (key_reg.proto == pffs_pkg::PROTO_UDP);
    assign is_ip  = (etype_reg == pffs_pkg::ETYPE_IPV4) ||
                    (etype_reg == pffs_pkg::ETYPE_IPV6);

    // Filter decision, formed in the compare cycle from the held header.
    always_comb
    begin
        case (mode_reg)
            pffs_pkg::MODE_TCP:  pass_next = is_tcp;
            pffs_pkg::MODE_UDP:  pass_next = is_udp;
            pffs_pkg::MODE_ADDR: pass_next = (key_reg.src == faddr_reg) ||
                                             (key_reg.dst == faddr_reg);
            pffs_pkg::MODE_PORT: pass_next = !(is_tcp || is_udp) ||
                                             (key_reg.sport == fport_reg) ||
                                             (key_reg.dport == fport_reg);
            default:             pass_next = 1'b1;
        endcase
    end

    assign do_lookup = pass_reg && (is_tcp || is_udp) && is_ip;
    assign insert    = upd_fire && do_lookup && !status.found && !status.full;
    assign full_flag = do_lookup && !status.found && status.full;

    pffs_flow_table u_table
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    (key_reg),
        .insert (insert),
        .status (status)
    );

    // Counter updates for a passing packet; only committed on upd_fire.
    always_comb
    begin
        pkt_total_next  = pkt_total_reg;
        pkt_tcp_next    = pkt_tcp_reg;
        pkt_udp_next    = pkt_udp_reg;
        pkt_other_next  = pkt_other_reg;
        byte_tcp_next   = byte_tcp_reg;
        byte_udp_next   = byte_udp_reg;
        flow_total_next = flow_total_reg;
        flow_tcp_next   = flow_tcp_reg;
        flow_udp_next   = flow_udp_reg;
        if (pass_reg)
        begin
            pkt_total_next = pffs_pkg::sat_add(pkt_total_reg, 16'd1);
            if (is_tcp)
            begin
                pkt_tcp_next = pffs_pkg::sat_add(pkt_tcp_reg, 16'd1);
            end
            else if (is_udp)
            begin
                pkt_udp_next = pffs_pkg::sat_add(pkt_udp_reg, 16'd1);
            end
            else
            begin
                pkt_other_next = pffs_pkg::sat_add(pkt_other_reg, 16'd1);
            end
        end
        if (do_lookup)
        begin
            if (is_tcp)
            begin
                byte_tcp_next = pffs_pkg::sat_add(byte_tcp_reg, len_reg);
            end
            else
            begin
                byte_udp_next = pffs_pkg::sat_add(byte_udp_reg, len_reg);
            end
        end
        if (insert)
        begin
            flow_total_next = pffs_pkg::sat_inc_flow(flow_total_reg);
            if (is_tcp)
            begin
                flow_tcp_next = pffs_pkg::sat_inc_flow(flow_tcp_reg);
            end
            else
            begin
                flow_udp_next = pffs_pkg::sat_inc_flow(flow_udp_reg);
            end
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = in_fire ? ST_CMP : ST_IDLE;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:  state_next = upd_fire ? ST_IDLE : ST_UPD;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= pffs_pkg::MODE_NONE;
            faddr_reg      <= '0;
            fport_reg      <= '0;
            pass_reg       <= 1'b0;
            pkt_total_reg  <= '0;
            pkt_tcp_reg    <= '0;
            pkt_udp_reg    <= '0;
            pkt_other_reg  <= '0;
            flow_total_reg <= '0;
            flow_tcp_reg   <= '0;
            flow_udp_reg   <= '0;
            byte_tcp_reg   <= '0;
            byte_udp_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    pffs_pkg::REG_FILTER_MODE:    mode_reg  <= cfg_data[2:0];
                    pffs_pkg::REG_FILTER_ADDRESS: faddr_reg <= cfg_data;
                    pffs_pkg::REG_FILTER_PORT:    fport_reg <= cfg_data[15:0];
                    default:                      ;
                endcase
            end
            if (state_reg == ST_CMP)
            begin
                pass_reg <= pass_next;
            end
            if (upd_fire)
            begin
                pkt_total_reg  <= pkt_total_next;
                pkt_tcp_reg    <= pkt_tcp_next;
                pkt_udp_reg    <= pkt_udp_next;
                pkt_other_reg  <= pkt_other_next;
                flow_total_reg <= flow_total_next;
                flow_tcp_reg   <= flow_tcp_next;
                flow_udp_reg   <= flow_udp_next;
                byte_tcp_reg   <= byte_tcp_next;
                byte_udp_reg   <= byte_udp_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            etype_reg     <= s_tdata[15:0];
            key_reg.proto <= s_tdata[23:16];
            key_reg.src   <= s_tdata[55:24];
            key_reg.dst   <= s_tdata[87:56];
            key_reg.sport <= s_tdata[103:88];
            key_reg.dport <= s_tdata[119:104];
            len_reg       <= s_tdata[135:120];
        end
        if (upd_fire)
        begin
            out_data_reg <= {byte_udp_next, byte_tcp_next,
                             flow_udp_next, flow_tcp_next, flow_total_next,
                             pkt_other_next, pkt_udp_next, pkt_tcp_next, pkt_total_next,
                             full_flag, insert, pass_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // A result never reports both a stored new flow and a full table.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
        else $error("new_flow and table_full both set");

    // Flow table activity only happens for packets that passed the filter.
    a_flow_needs_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1] || m_tdata[2]) |-> m_tdata[0])
        else $error("flow flag on a rejected packet");

    // A flow insert always shows up in the stored flow count at the next edge.
    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        insert |=> (flow_total_reg != '0))
        else $error("flow inserted but flow total is zero");

    // The packet total only moves on an update.
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !upd_fire |=> $stable(pkt_total_reg))
        else $error("packet total changed outside an update");
`endif

endmodule

>>> tb/sv/packet_flow_filter_stats_unit_tb.sv
// Self-checking testbench for packet_flow_filter_stats_unit: packet filter, counters, flow table.
// Depends on pffs_pkg and the unit's RTL; a predictor inside this file computes every result.
`timescale 1ns / 100ps

module packet_flow_filter_stats_unit_tb;

    // Header layout, first member in the highest bits, so that it matches s_tdata directly.
    typedef struct packed {
        logic [15:0] length;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
        logic [7:0]  proto;
        logic [15:0] etype;
    } header_t;

    // Result layout in the same order as m_tdata, highest bits first.
    typedef struct packed {
        logic [31:0] udp_byte_total;
        logic [31:0] tcp_byte_total;
        logic [6:0]  udp_flow_total;
        logic [6:0]  tcp_flow_total;
        logic [6:0]  flow_total;
        logic [31:0] other_packet_total;
        logic [31:0] udp_packet_total;
        logic [31:0] tcp_packet_total;
        logic [31:0] packet_total;
        logic        table_full;
        logic        new_flow;
        logic        passed;
    } result_t;

    localparam logic [2:0]  MODE_SPARE_A = 3'd5;
    localparam logic [2:0]  MODE_SPARE_B = 3'd6;
    localparam logic [2:0]  MODE_SPARE_C = 3'd7;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;
    localparam logic [15:0] ETYPE_ARP    = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP   = 8'd1;

    localparam int POOL_SIZE    = 48;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_REPORTS  = 100;
    localparam int CYCLE_LIMIT  = 3_000_000;

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [pffs_pkg::IN_W-1:0]    s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [pffs_pkg::OUT_W-1:0]   m_tdata;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [1:0]                   cfg_index;
    logic [31:0]                  cfg_data;

    // Predictor state: filter settings, stored five-tuples and running totals.
    logic [2:0]           filt_mode = pffs_pkg::MODE_NONE;
    logic [31:0]          filt_addr = '0;
    logic [15:0]          filt_port = '0;
    pffs_pkg::flow_key_t  stored_keys [pffs_pkg::FLOW_ENTRIES];
    logic                 slot_taken  [pffs_pkg::FLOW_ENTRIES];
    result_t              tally = '0;

    result_t              pending_results [$];
    pffs_pkg::flow_key_t  flow_pool [POOL_SIZE];

    int src_idle_pct      = 0;
    int snk_idle_pct      = 0;
    int sink_hold_cycles  = 0;
    int error_count       = 0;
    int headers_sent      = 0;
    int results_checked   = 0;
    int rejected_count    = 0;
    int flows_added       = 0;
    int full_drops        = 0;
    int cycle_count       = 0;

    packet_flow_filter_stats_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit; a correct run stays well under it.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    function automatic logic [6:0] sat_flow(input logic [6:0] c);
        return (c == '1) ? c : c + 7'd1;
    endfunction

    // Applies one accepted header to the predictor state and returns the expected result.
    function automatic result_t predict_packet(input header_t h);
        result_t             r;
        logic                is_tcp;
        logic                is_udp;
        logic                hit;
        logic                found;
        logic                added;
        logic                dropped;
        int                  free_slot;
        pffs_pkg::flow_key_t key;
        is_tcp  = (h.proto == pffs_pkg::PROTO_TCP);
        is_udp  = (h.proto == pffs_pkg::PROTO_UDP);
        added   = 1'b0;
        dropped = 1'b0;
        case (filt_mode)
            pffs_pkg::MODE_TCP:  hit = is_tcp;
            pffs_pkg::MODE_UDP:  hit = is_udp;
            pffs_pkg::MODE_ADDR: hit = (h.src_addr == filt_addr) || (h.dst_addr == filt_addr);
            // Port mode lets everything that has no ports straight through.
            pffs_pkg::MODE_PORT: hit = (is_tcp || is_udp) ?
                                       ((h.src_port == filt_port) ||
                                        (h.dst_port == filt_port)) : 1'b1;
            default:             hit = 1'b1;
        endcase
        if (hit)
        begin
            tally.packet_total = sat_add32(tally.packet_total, 16'd1);
            if (is_tcp)
                tally.tcp_packet_total = sat_add32(tally.tcp_packet_total, 16'd1);
            else if (is_udp)
                tally.udp_packet_total = sat_add32(tally.udp_packet_total, 16'd1);
            else
                tally.other_packet_total = sat_add32(tally.other_packet_total, 16'd1);
            // Only TCP/UDP over an IP ethertype reaches the byte totals and the flow table.
            if ((is_tcp || is_udp) &&
                (h.etype == pffs_pkg::ETYPE_IPV4 || h.etype == pffs_pkg::ETYPE_IPV6))
            begin
                if (is_tcp)
                    tally.tcp_byte_total = sat_add32(tally.tcp_byte_total, h.length);
                else
                    tally.udp_byte_total = sat_add32(tally.udp_byte_total, h.length);
                key       = {h.src_addr, h.dst_addr, h.proto, h.src_port, h.dst_port};
                found     = 1'b0;
                free_slot = -1;
                for (int i = 0; i < pffs_pkg::FLOW_ENTRIES; i++)
                begin
                    if (slot_taken[i])
                    begin
                        if (stored_keys[i] == key)
                            found = 1'b1;
                    end
                    else if (free_slot < 0)
                    begin
                        free_slot = i;
                    end
                end
                if (!found && free_slot >= 0)
                begin
                    stored_keys[free_slot] = key;
                    slot_taken[free_slot]  = 1'b1;
                    added                  = 1'b1;
                    flows_added++;
                    tally.flow_total = sat_flow(tally.flow_total);
                    if (is_tcp)
                        tally.tcp_flow_total = sat_flow(tally.tcp_flow_total);
                    else
                        tally.udp_flow_total = sat_flow(tally.udp_flow_total);
                end
                else if (!found)
                begin
                    dropped = 1'b1;
                    full_drops++;
                end
            end
        end
        else
        begin
            rejected_count++;
        end
        r            = tally;
        r.passed     = hit;
        r.new_flow   = added;
        r.table_full = dropped;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endtask

    result_t got_result;
    result_t want_result;

    // Every result transfer is matched against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result = result_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t ns: unexpected result, expected none, actual %0h",
                             $time, m_tdata);
            end
            else
            begin
                want_result = pending_results.pop_front();
                results_checked++;
                compare_field("passed", want_result.passed, got_result.passed);
                compare_field("new_flow", want_result.new_flow, got_result.new_flow);
                compare_field("table_full", want_result.table_full, got_result.table_full);
                compare_field("packet_total", want_result.packet_total,
                              got_result.packet_total);
                compare_field("tcp_packet_total", want_result.tcp_packet_total,
                              got_result.tcp_packet_total);
                compare_field("udp_packet_total", want_result.udp_packet_total,
                              got_result.udp_packet_total);
                compare_field("other_packet_total", want_result.other_packet_total,
                              got_result.other_packet_total);
                compare_field("flow_total", want_result.flow_total, got_result.flow_total);
                compare_field("tcp_flow_total", want_result.tcp_flow_total,
                              got_result.tcp_flow_total);
                compare_field("udp_flow_total", want_result.udp_flow_total,
                              got_result.udp_flow_total);
                compare_field("tcp_byte_total", want_result.tcp_byte_total,
                              got_result.tcp_byte_total);
                compare_field("udp_byte_total", want_result.udp_byte_total,
                              got_result.udp_byte_total);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one; none at all when pct is zero.
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        int len;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_cycles > 0)
            begin
                len              = sink_hold_cycles;
                sink_hold_cycles = 0;
                m_tready <= 1'b0;
                repeat (len) @(negedge clk);
            end
            else
            begin
                len = pick_gap(snk_idle_pct);
                if (len > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (len - 1) @(negedge clk);
                end
                else
                begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    function automatic header_t make_header(input logic [15:0] etype, input logic [7:0] proto,
                                            input logic [31:0] sa, input logic [31:0] da,
                                            input logic [15:0] sp, input logic [15:0] dp,
                                            input logic [15:0] len);
        return {len, dp, sp, da, sa, proto, etype};
    endfunction

    // Mostly well-formed TCP/UDP headers, many of them repeating pool flows; the rest is
    // non-IP or random-protocol noise. aim_pct steers some headers onto the filter values.
    function automatic header_t random_header(input int aim_pct);
        header_t             h;
        pffs_pkg::flow_key_t k;
        int                  r;
        r          = $urandom_range(99);
        h.length   = 16'($urandom);
        h.src_addr = $urandom;
        h.dst_addr = $urandom;
        h.src_port = 16'($urandom);
        h.dst_port = 16'($urandom);
        h.etype    = $urandom_range(1) ? pffs_pkg::ETYPE_IPV4 : pffs_pkg::ETYPE_IPV6;
        h.proto    = $urandom_range(1) ? pffs_pkg::PROTO_TCP : pffs_pkg::PROTO_UDP;
        if (r < 55)
        begin
            k          = flow_pool[$urandom_range(POOL_SIZE - 1)];
            h.src_addr = k.src;
            h.dst_addr = k.dst;
            h.proto    = k.proto;
            h.src_port = k.sport;
            h.dst_port = k.dport;
        end
        else if (r >= 78 && r < 88)
        begin
            h.etype = 16'($urandom);
        end
        else if (r >= 88)
        begin
            h.proto = 8'($urandom);
            if ($urandom_range(1))
                h.etype = 16'($urandom);
        end
        if ($urandom_range(99) < aim_pct)
        begin
            case ($urandom_range(3))
                0: h.src_addr = filt_addr;
                1: h.dst_addr = filt_addr;
                2: h.src_port = filt_port;
                default: h.dst_port = filt_port;
            endcase
        end
        return h;
    endfunction

    // Offers one header; starts and ends at a falling edge. tvalid stays high on return so
    // that back-to-back headers need no idle cycle in between.
    task automatic send_packet(input header_t h);
        int gap;
        gap = pick_gap(src_idle_pct);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= h;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_packet(h));
        headers_sent++;
        @(negedge clk);
    endtask

    task automatic send_burst(input int count, input int aim_pct);
        for (int i = 0; i < count; i++)
            send_packet(random_header(aim_pct));
    endtask

    // Register writes happen only with the unit drained of all outstanding work.
    task automatic write_register(input logic [1:0] index, input logic [31:0] data);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            pffs_pkg::REG_FILTER_MODE:    filt_mode = data[2:0];
            pffs_pkg::REG_FILTER_ADDRESS: filt_addr = data;
            pffs_pkg::REG_FILTER_PORT:    filt_port = data[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Writes all three filter registers; unused upper data bits carry random junk.
    task automatic configure(input logic [2:0] mode, input logic [31:0] addr,
                             input logic [15:0] port);
        logic [31:0] junk;
        junk = $urandom;
        write_register(pffs_pkg::REG_FILTER_MODE, {junk[31:3], mode});
        write_register(pffs_pkg::REG_FILTER_ADDRESS, addr);
        junk = $urandom;
        write_register(pffs_pkg::REG_FILTER_PORT, {junk[31:16], port});
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, flow hits and misses, non-IP ethertypes and other protocols,
    // all with the filter at its reset setting.
    task automatic test_directed_headers();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_packet(make_header(pffs_pkg::ETYPE_IPV4, pffs_pkg::PROTO_TCP,
                                '0, '0, '0, '0, '0));
        send_packet(make_header(pffs_pkg::ETYPE_IPV4, pffs_pkg::PROTO_TCP,
                                '0, '0, '0, '0, '0));
        // Same five-tuple over the other IP ethertype is the same flow.
        send_packet(make_header(pffs_pkg::ETYPE_IPV6, pffs_pkg::PROTO_TCP,
                                '0, '0, '0, '0, '1));
        send_packet(make_header(pffs_pkg::ETYPE_IPV4, pffs_pkg::PROTO_TCP,
                                '1, '1, '1, '1, '1));
        send_packet(make_header(pffs_pkg::ETYPE_IPV4, pffs_pkg::PROTO_UDP,
                                '1, '1, '1, '1, '1));
        send_packet(make_header(pffs_pkg::ETYPE_IPV6, pffs_pkg::PROTO_UDP,
                                '0, '0, '0, '0, 16'd1));
        send_packet(make_header(pffs_pkg::ETYPE_IPV4, pffs_pkg::PROTO_TCP,
                                32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80, 16'd64));
        send_packet(make_header(pffs_pkg::ETYPE_IPV4, pffs_pkg::PROTO_TCP,
                                32'h0A00_0002, 32'h0A00_0001, 16'd80, 16'd1234, 16'd1500));
        send_packet(make_header(pffs_pkg::ETYPE_IPV6, pffs_pkg::PROTO_TCP,
                                32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80, 16'd40));
        // TCP/UDP behind a non-IP ethertype: counted, but no bytes and no lookup.
        send_packet(make_header(ETYPE_ARP, pffs_pkg::PROTO_TCP,
                                32'h1, 32'h2, 16'd3, 16'd4, 16'd99));
        send_packet(make_header('0, pffs_pkg::PROTO_UDP, 32'h5, 32'h6, 16'd7, 16'd8, 16'd100));
        send_packet(make_header('1, pffs_pkg::PROTO_UDP, 32'h5, 32'h6, 16'd7, 16'd8, '1));
        send_packet(make_header(pffs_pkg::ETYPE_IPV4 + 16'd1, pffs_pkg::PROTO_TCP,
                                32'h9, 32'hA, 16'd1, 16'd2, 16'd60));
        send_packet(make_header(pffs_pkg::ETYPE_IPV6 - 16'd1, pffs_pkg::PROTO_UDP,
                                32'h9, 32'hA, 16'd1, 16'd2, 16'd60));
        // Other protocols, near misses of TCP and UDP among them.
        send_packet(make_header(pffs_pkg::ETYPE_IPV4, PROTO_ICMP,
                                32'hC0A8_0001, 32'hC0A8_0002, '0, '0, 16'd84));
        send_packet(make_header(pffs_pkg::ETYPE_IPV4, '0, '0, '0, '0, '0, '0));
        send_packet(make_header(pffs_pkg::ETYPE_IPV6, '1, '1, '1, '1, '1, '1));
        send_packet(make_header('1, '1, '1, '1, '1, '1, '1));
        send_packet(make_header(pffs_pkg::ETYPE_IPV4, pffs_pkg::PROTO_TCP + 8'd1,
                                '1, '0, '1, '0, 16'd20));
        send_packet(make_header(pffs_pkg::ETYPE_IPV4, pffs_pkg::PROTO_UDP - 8'd1,
                                '0, '1, '0, '1, 16'd20));
        // Same addresses and ports as the zero TCP flow but UDP: a separate flow.
        send_packet(make_header(pffs_pkg::ETYPE_IPV4, pffs_pkg::PROTO_UDP,
                                '0, '0, '0, '0, 16'd8));
    endtask

    // Every filter mode, the unused codes included, with address and port extremes.
    task automatic test_filter_modes();
        src_idle_pct = 20;
        snk_idle_pct = 20;
        // A write to the unused register index must leave the filter alone.
        write_register(REG_UNUSED, $urandom);
        send_burst(6, 30);
        configure(pffs_pkg::MODE_TCP, $urandom, 16'($urandom));
        send_burst(10, 30);
        configure(pffs_pkg::MODE_UDP, $urandom, 16'($urandom));
        send_burst(10, 30);
        configure(pffs_pkg::MODE_ADDR, '0, 16'($urandom));
        send_burst(10, 50);
        configure(pffs_pkg::MODE_ADDR, '1, 16'($urandom));
        send_burst(10, 50);
        configure(pffs_pkg::MODE_ADDR, flow_pool[0].src, 16'($urandom));
        send_burst(10, 30);
        configure(pffs_pkg::MODE_PORT, $urandom, '0);
        send_burst(10, 50);
        configure(pffs_pkg::MODE_PORT, $urandom, '1);
        send_burst(10, 50);
        configure(pffs_pkg::MODE_PORT, $urandom, flow_pool[1].dport);
        send_burst(10, 30);
        configure(MODE_SPARE_A, $urandom, 16'($urandom));
        send_burst(6, 30);
        configure(MODE_SPARE_B, $urandom, 16'($urandom));
        send_burst(6, 30);
        configure(MODE_SPARE_C, '1, '1);
        send_burst(6, 30);
    endtask

    // The receiver holds off for a long stretch while headers keep coming, so the unit
    // fills up and has to stall its input.
    task automatic test_backpressure();
        write_register(pffs_pkg::REG_FILTER_MODE, 32'(pffs_pkg::MODE_NONE));
        src_idle_pct     = 0;
        snk_idle_pct     = 0;
        sink_hold_cycles = HOLD_CYCLES;
        send_burst(16, 0);
    endtask

    // Phases of random traffic, each under its own filter setting and idle pattern.
    // The first phase runs with no idling on either side.
    task automatic test_random_traffic();
        logic [2:0]  mode;
        logic [31:0] addr;
        logic [15:0] port;
        for (int phase = 0; phase < 8; phase++)
        begin
            mode = (phase == 0) ? pffs_pkg::MODE_NONE : 3'($urandom_range(7));
            case ($urandom_range(3))
                0: addr = '0;
                1: addr = '1;
                2: addr = flow_pool[$urandom_range(POOL_SIZE - 1)].src;
                default: addr = $urandom;
            endcase
            case ($urandom_range(3))
                0: port = '0;
                1: port = '1;
                2: port = flow_pool[$urandom_range(POOL_SIZE - 1)].sport;
                default: port = 16'($urandom);
            endcase
            configure(mode, addr, port);
            src_idle_pct = (phase == 0) ? 0 : $urandom_range(60);
            snk_idle_pct = (phase == 0) ? 0 : $urandom_range(60);
            send_burst(100, 30);
        end
    endtask

    // Two known flows at the largest captured length, back to back, with the filter
    // at its reset setting.
    task automatic test_max_length();
        configure(pffs_pkg::MODE_NONE, '0, '0);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        for (int i = 0; i < 4; i++)
        begin
            send_packet(make_header(pffs_pkg::ETYPE_IPV4, pffs_pkg::PROTO_TCP,
                                    '1, '1, '1, '1, '1));
            send_packet(make_header(pffs_pkg::ETYPE_IPV6, pffs_pkg::PROTO_UDP,
                                    '1, '1, '1, '1, '1));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = pffs_pkg::REG_FILTER_MODE;
        cfg_data  = '0;
        for (int i = 0; i < pffs_pkg::FLOW_ENTRIES; i++)
            slot_taken[i] = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
            flow_pool[i] = {$urandom, $urandom,
                            ($urandom_range(1) ? pffs_pkg::PROTO_TCP : pffs_pkg::PROTO_UDP),
                            16'($urandom), 16'($urandom)};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_headers();
        test_filter_modes();
        test_backpressure();
        test_random_traffic();
        test_max_length();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d headers and %0d checked results, %0d filtered out, %0d %s",
                 headers_sent, results_checked, rejected_count, error_count, "mismatches");
        $display("Flow table took %0d flows and turned away %0d; byte totals reached %0h / %0h",
                 flows_added, full_drops, tally.tcp_byte_total, tally.udp_byte_total);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/pffs_pkg.sv
rtl/core/pffs_flow_cell.sv
rtl/core/pffs_flow_table.sv
rtl/core/packet_flow_filter_stats_unit.sv
tb/sv/packet_flow_filter_stats_unit_tb.sv
